// ===== sv/tkst_pkg.sv =====
// ----------------------------------------------------------------------------
// tkst_pkg: shared types and constants for the top-k score tracker
// Item layouts, command codes and the control bundle for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

	localparam int K_MAX      = 16;
	localparam int SCORE_BITS = 32;
	localparam int ID_BITS    = 16;
	localparam int CNT_BITS   = 5;
	localparam logic [CNT_BITS-1:0] K_RESET = CNT_BITS'(10);

	typedef enum logic [1:0] {
		CMD_OFFER = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                  command;
		logic [SCORE_BITS-1:0] score;
		logic [ID_BITS-1:0]    doc_id;
	} req_item_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    entry_id;
		logic [SCORE_BITS-1:0] entry_score;
		logic [SCORE_BITS-1:0] threshold;
		logic [CNT_BITS-1:0]   held_count;
		logic                  accepted;
		logic                  valid_res;
		logic                  last;
	} rsp_item_t;

	// broadcast to every cell
	typedef struct packed {
		logic                  ins;
		logic                  rot;
		logic [SCORE_BITS-1:0] score;
		logic [ID_BITS-1:0]    id;
	} cell_ctl_t;

	// per-operation result pending for the output register
	typedef struct packed {
		logic valid;
		logic accepted;
	} op_info_t;

endpackage

`default_nettype wire

// ===== sv/tkst_cell.sv =====
// ----------------------------------------------------------------------------
// tkst_cell: one slot of the sorted score chain
// Holds one entry; on insert keeps, takes the new item or shifts from its
// upper neighbor; on readout rotates toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_cell (
	input  wire                              clk,
	input  wire tkst_pkg::cell_ctl_t         ctl,
	input  wire                              occ,
	input  wire                              tail,
	input  wire                              prev_ge,
	input  wire [tkst_pkg::SCORE_BITS-1:0]   prev_score,
	input  wire [tkst_pkg::ID_BITS-1:0]      prev_id,
	input  wire [tkst_pkg::SCORE_BITS-1:0]   next_score,
	input  wire [tkst_pkg::ID_BITS-1:0]      next_id,
	input  wire [tkst_pkg::SCORE_BITS-1:0]   head_score,
	input  wire [tkst_pkg::ID_BITS-1:0]      head_id,
	output logic                             ge,
	output logic [tkst_pkg::SCORE_BITS-1:0]  score,
	output logic [tkst_pkg::ID_BITS-1:0]     id
);

	logic [tkst_pkg::SCORE_BITS-1:0] score_q;
	logic [tkst_pkg::ID_BITS-1:0]    id_q;

	assign ge    = occ && (score_q >= ctl.score);
	assign score = score_q;
	assign id    = id_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !ge) begin
			if (prev_ge) begin
				score_q <= ctl.score;
				id_q    <= ctl.id;
			end else begin
				score_q <= prev_score;
				id_q    <= prev_id;
			end
		end else if (ctl.rot) begin
			if (tail) begin
				score_q <= head_score;
				id_q    <= head_id;
			end else begin
				score_q <= next_score;
				id_q    <= next_id;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/top_k_score_tracker.sv =====
// ----------------------------------------------------------------------------
// top_k_score_tracker: keeps the k best-scoring documents of a search
// Sorted chain of cells with offer, clear and readout commands.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on request with start high; it is taken when busy is
//   low. Offer, clear and the unused command each give one result, registered
//   in op_s1 and then in the done/result register (done high for one cycle);
//   one such item can be taken every cycle while busy is low. An offer is
//   sorted into the chain in the cycle it is taken: every cell compares
//   against the new score and keeps, takes it, or shifts from its neighbor.
//   Readout of n held entries (n > 0) raises busy while the chain rotates
//   through the held cells; the n results follow back to back, highest
//   score first, last set on the final one.
//   An empty readout gives one result like an offer.
//   cfg_we/cfg_wdata write k_wanted (reset 10); write only while idle.
//   Reset empties the list and clears all handshake state. The receiver
//   cannot stall: done marks a result valid for exactly that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_tracker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire tkst_pkg::req_item_t         request,
	output logic                             done,
	output tkst_pkg::rsp_item_t              result,
	input  wire                              cfg_we,
	input  wire [tkst_pkg::CNT_BITS-1:0]     cfg_wdata
);

	localparam int K_MAX      = tkst_pkg::K_MAX;
	localparam int SCORE_BITS = tkst_pkg::SCORE_BITS;
	localparam int ID_BITS    = tkst_pkg::ID_BITS;
	localparam int CNT_BITS   = tkst_pkg::CNT_BITS;

	logic [CNT_BITS-1:0]   k_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  rd_active_q;
	logic [CNT_BITS-1:0]   rd_left_q;
	logic [SCORE_BITS-1:0] thr_hold_q;
	tkst_pkg::op_info_t    op_s1;
	logic                  done_q;
	tkst_pkg::rsp_item_t   result_q;

	logic [CNT_BITS-1:0]   k_eff;
	logic                  full;
	logic [SCORE_BITS-1:0] thr_sel;
	logic [SCORE_BITS-1:0] thr_now;
	logic                  offer_acc;
	logic                  accept;
	tkst_pkg::cell_ctl_t   ctl;

	logic                  occ   [K_MAX];
	logic                  tail  [K_MAX];
	logic                  ge    [K_MAX];
	logic [SCORE_BITS-1:0] c_score [K_MAX];
	logic [ID_BITS-1:0]    c_id    [K_MAX];

	assign busy   = rd_active_q;
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		if (k_q == '0) begin
			k_eff = CNT_BITS'(1);
		end else if (k_q > CNT_BITS'(K_MAX)) begin
			k_eff = CNT_BITS'(K_MAX);
		end else begin
			k_eff = k_q;
		end
	end

	assign full = count_q >= k_eff;

	always_comb begin
		thr_sel = '0;
		for (int i = 0; i < K_MAX; i++) begin
			thr_sel = thr_sel | (tail[i] ? c_score[i] : '0);
		end
	end

	assign thr_now   = full ? thr_sel : '0;
	assign offer_acc = (request.score != '0) && (!full || (request.score > thr_now));

	always_comb begin
		ctl.ins   = accept && (request.command == tkst_pkg::CMD_OFFER) && offer_acc;
		ctl.rot   = rd_active_q;
		ctl.score = request.score;
		ctl.id    = request.doc_id;
	end

	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		assign occ[i]  = count_q > CNT_BITS'(i);
		assign tail[i] = count_q == CNT_BITS'(i + 1);

		if (i == 0) begin : g_head
			if (K_MAX > 1) begin : g_nxt
				tkst_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.occ        (occ[i]),
					.tail       (tail[i]),
					.prev_ge    (1'b1),
					.prev_score ('0),
					.prev_id    ('0),
					.next_score (c_score[i+1]),
					.next_id    (c_id[i+1]),
					.head_score (c_score[0]),
					.head_id    (c_id[0]),
					.ge         (ge[i]),
					.score      (c_score[i]),
					.id         (c_id[i])
				);
			end else begin : g_one
				tkst_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.occ        (occ[i]),
					.tail       (tail[i]),
					.prev_ge    (1'b1),
					.prev_score ('0),
					.prev_id    ('0),
					.next_score ('0),
					.next_id    ('0),
					.head_score (c_score[0]),
					.head_id    (c_id[0]),
					.ge         (ge[i]),
					.score      (c_score[i]),
					.id         (c_id[i])
				);
			end
		end else if (i == K_MAX - 1) begin : g_end
			tkst_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occ        (occ[i]),
				.tail       (tail[i]),
				.prev_ge    (ge[i-1]),
				.prev_score (c_score[i-1]),
				.prev_id    (c_id[i-1]),
				.next_score ('0),
				.next_id    ('0),
				.head_score (c_score[0]),
				.head_id    (c_id[0]),
				.ge         (ge[i]),
				.score      (c_score[i]),
				.id         (c_id[i])
			);
		end else begin : g_mid
			tkst_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occ        (occ[i]),
				.tail       (tail[i]),
				.prev_ge    (ge[i-1]),
				.prev_score (c_score[i-1]),
				.prev_id    (c_id[i-1]),
				.next_score (c_score[i+1]),
				.next_id    (c_id[i+1]),
				.head_score (c_score[0]),
				.head_id    (c_id[0]),
				.ge         (ge[i]),
				.score      (c_score[i]),
				.id         (c_id[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= tkst_pkg::K_RESET;
		end else if (cfg_we) begin
			k_q <= cfg_wdata;
		end
	end

	// list count, readout sequencing, pending op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_active_q <= 1'b0;
			rd_left_q   <= '0;
			op_s1       <= '0;
		end else begin
			op_s1.valid    <= accept &&
				((request.command != tkst_pkg::CMD_READ) || (count_q == '0));
			op_s1.accepted <= accept &&
				(request.command == tkst_pkg::CMD_OFFER) && offer_acc;
			if (rd_active_q) begin
				rd_left_q <= rd_left_q - CNT_BITS'(1);
				if (rd_left_q == CNT_BITS'(1)) begin
					rd_active_q <= 1'b0;
				end
			end
			if (accept) begin
				case (request.command)
					tkst_pkg::CMD_OFFER: begin
						if (offer_acc && !full) begin
							count_q <= count_q + CNT_BITS'(1);
						end
					end
					tkst_pkg::CMD_CLEAR: begin
						count_q <= '0;
					end
					tkst_pkg::CMD_READ: begin
						if (count_q != '0) begin
							rd_active_q <= 1'b1;
							rd_left_q   <= count_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (request.command == tkst_pkg::CMD_READ)) begin
			thr_hold_q <= thr_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= op_s1.valid || rd_active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_active_q) begin
			result_q.entry_id    <= c_id[0];
			result_q.entry_score <= c_score[0];
			result_q.threshold   <= thr_hold_q;
			result_q.held_count  <= count_q;
			result_q.accepted    <= 1'b0;
			result_q.valid_res   <= 1'b1;
			result_q.last        <= rd_left_q == CNT_BITS'(1);
		end else begin
			result_q.entry_id    <= '0;
			result_q.entry_score <= '0;
			result_q.threshold   <= thr_now;
			result_q.held_count  <= count_q;
			result_q.accepted    <= op_s1.accepted;
			result_q.valid_res   <= 1'b0;
			result_q.last        <= 1'b1;
		end
	end

	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> !op_s1.valid)
		else $error("pending op during readout");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !result_q.last) |=> done_q)
		else $error("readout burst broken");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(K_MAX))
		else $error("held count above capacity");

	a_read_left: assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> (rd_left_q != '0) && (rd_left_q <= count_q))
		else $error("readout counter out of range");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> (count_q == $past(count_q)) ||
			(count_q == $past(count_q) + CNT_BITS'(1)))
		else $error("insert changed count wrongly");

endmodule

`default_nettype wire

// ===== tb/top_k_score_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_tracker_test: self-checking bench for the top-k score tracker
// Offers, clears, readouts and unused commands are sent in random bursts from
// a queue, and the k_wanted register is changed between phases while the
// block is idle. A local sorted-list model predicts each result. The monitor
// checks every strobed result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module top_k_score_tracker_test;

	localparam int SETTLE = 4;

	typedef enum {PLAN_ITEM, PLAN_CFG, PLAN_DRAIN} plan_kind_t;

	typedef struct {
		plan_kind_t                    kind;
		tkst_pkg::req_item_t           req;
		logic [tkst_pkg::CNT_BITS-1:0] k;
	} plan_step_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	tkst_pkg::req_item_t           request = '0;
	logic                          done;
	tkst_pkg::rsp_item_t           result;
	logic                          cfg_we = 1'b0;
	logic [tkst_pkg::CNT_BITS-1:0] cfg_wdata = '0;

	plan_step_t          plan_q[$];
	tkst_pkg::rsp_item_t owed_results[$];
	int                  errors = 0;

	// sorted list model, highest score first
	logic [tkst_pkg::SCORE_BITS-1:0] held_score [tkst_pkg::K_MAX];
	logic [tkst_pkg::ID_BITS-1:0]    held_id [tkst_pkg::K_MAX];
	int                              held_n = 0;
	logic [tkst_pkg::CNT_BITS-1:0]   k_reg = tkst_pkg::K_RESET;

	int burst_left = 1;
	int gap_left = 0;
	int quiet = 0;

	top_k_score_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void predict_ranking(tkst_pkg::req_item_t r);
		int                  k;
		int                  pos;
		int                  i;
		logic                took;
		tkst_pkg::rsp_item_t o;
		k = (k_reg == 0) ? 1 : (k_reg > tkst_pkg::K_MAX) ? tkst_pkg::K_MAX : int'(k_reg);
		took = 1'b0;
		if (r.command == tkst_pkg::CMD_OFFER) begin
			if (r.score != 0 &&
			    !(held_n >= k && (held_n == 0 || r.score <= held_score[held_n-1]))) begin
				if (held_n >= k)
					held_n--;
				if (held_n < tkst_pkg::K_MAX) begin
					pos = 0;
					while (pos < held_n && held_score[pos] >= r.score)
						pos++;
					for (i = held_n; i > pos; i--) begin
						held_score[i] = held_score[i-1];
						held_id[i] = held_id[i-1];
					end
					held_score[pos] = r.score;
					held_id[pos] = r.doc_id;
					held_n++;
					took = 1'b1;
				end
			end
		end else if (r.command == tkst_pkg::CMD_CLEAR) begin
			held_n = 0;
		end
		o = '0;
		o.threshold = (held_n >= k && held_n > 0) ? held_score[held_n-1] : '0;
		o.held_count = tkst_pkg::CNT_BITS'(held_n);
		o.last = 1'b1;
		if (r.command == tkst_pkg::CMD_READ && held_n > 0) begin
			for (i = 0; i < held_n; i++) begin
				o.entry_id = held_id[i];
				o.entry_score = held_score[i];
				o.valid_res = 1'b1;
				o.last = (i == held_n - 1);
				owed_results = {owed_results, o};
			end
		end else begin
			o.accepted = took;
			owed_results = {owed_results, o};
		end
	endfunction

	function automatic void add_item(tkst_pkg::cmd_t c,
			logic [tkst_pkg::SCORE_BITS-1:0] s, logic [tkst_pkg::ID_BITS-1:0] id);
		plan_step_t p;
		p.kind = PLAN_ITEM;
		p.req.command = c;
		p.req.score = s;
		p.req.doc_id = id;
		p.k = '0;
		plan_q = {plan_q, p};
	endfunction

	function automatic void add_cfg(logic [tkst_pkg::CNT_BITS-1:0] k);
		plan_step_t p;
		p.kind = PLAN_CFG;
		p.req = '0;
		p.k = k;
		plan_q = {plan_q, p};
	endfunction

	function automatic void add_drain();
		plan_step_t p;
		p.kind = PLAN_DRAIN;
		p.req = '0;
		p.k = '0;
		plan_q = {plan_q, p};
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// driver: one item per start, held while busy
	always @(posedge clk or negedge arst_n) begin
		logic next_start;
		logic next_we;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			request <= '0;
			cfg_wdata <= '0;
		end else begin
			next_start = start;
			next_we = 1'b0;
			if (start && !busy) begin
				predict_ranking(request);
				next_start = 1'b0;
			end
			quiet = (owed_results.size() == 0 && !next_start) ? quiet + 1 : 0;
			if (!next_start && plan_q.size() > 0) begin
				if (plan_q[0].kind == PLAN_CFG) begin
					if (quiet >= SETTLE) begin
						next_we = 1'b1;
						cfg_wdata <= plan_q[0].k;
						k_reg = plan_q[0].k;
						void'(plan_q.pop_front());
						quiet = 0;
					end
				end else if (plan_q[0].kind == PLAN_DRAIN) begin
					if (quiet >= SETTLE)
						void'(plan_q.pop_front());
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					next_start = 1'b1;
					request <= plan_q[0].req;
					void'(plan_q.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			start <= next_start;
			cfg_we <= next_we;
		end
	end

	// monitor: results cannot be held off
	always @(posedge clk) begin
		tkst_pkg::rsp_item_t want;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				$error("result with nothing expected: %h", result);
				errors++;
			end else begin
				want = owed_results.pop_front();
				check_field("entry_id", 64'(want.entry_id), 64'(result.entry_id));
				check_field("entry_score", 64'(want.entry_score),
					64'(result.entry_score));
				check_field("threshold", 64'(want.threshold), 64'(result.threshold));
				check_field("held_count", 64'(want.held_count),
					64'(result.held_count));
				check_field("accepted", 64'(want.accepted), 64'(result.accepted));
				check_field("valid_res", 64'(want.valid_res), 64'(result.valid_res));
				check_field("last", 64'(want.last), 64'(result.last));
			end
		end
	end

	initial begin
		int                              n;
		int                              r;
		int                              c;
		logic [tkst_pkg::SCORE_BITS-1:0] s;
		logic [tkst_pkg::CNT_BITS-1:0]   k;

		// directed: empty list, extremes, ties, unused command, clear
		add_item(tkst_pkg::CMD_READ, '0, '0);
		add_item(tkst_pkg::CMD_OFFER, '0, 16'hFFFF);
		add_item(tkst_pkg::CMD_OFFER, 32'hFFFF_FFFF, 16'hFFFF);
		add_item(tkst_pkg::CMD_OFFER, 32'd1, 16'h0000);
		add_item(tkst_pkg::CMD_OFFER, 32'd5 << 16, 16'd1);
		add_item(tkst_pkg::CMD_OFFER, 32'd5 << 16, 16'd2);
		add_item(tkst_pkg::CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF);
		add_item(tkst_pkg::CMD_READ, '0, '0);
		add_item(tkst_pkg::CMD_CLEAR, '0, '0);
		add_item(tkst_pkg::CMD_READ, '0, '0);

		// k = 1: equal score rejected when full
		add_cfg(5'd1);
		add_item(tkst_pkg::CMD_OFFER, 32'd3 << 16, 16'd3);
		add_item(tkst_pkg::CMD_OFFER, 32'd3 << 16, 16'd4);
		add_item(tkst_pkg::CMD_OFFER, 32'd4 << 16, 16'd5);
		add_item(tkst_pkg::CMD_READ, '0, '0);

		// k lowered below the held count
		add_cfg(5'd4);
		add_item(tkst_pkg::CMD_CLEAR, '0, '0);
		add_item(tkst_pkg::CMD_OFFER, 32'd7 << 16, 16'd10);
		add_item(tkst_pkg::CMD_OFFER, 32'd9 << 16, 16'd11);
		add_item(tkst_pkg::CMD_OFFER, 32'd8 << 16, 16'd12);
		add_item(tkst_pkg::CMD_OFFER, 32'd6 << 16, 16'd13);
		add_cfg(5'd2);
		add_item(tkst_pkg::CMD_OFFER, 32'd5 << 16, 16'd14);
		add_item(tkst_pkg::CMD_OFFER, 32'd10 << 16, 16'd15);
		add_item(tkst_pkg::CMD_READ, '0, '0);

		// random phases over a range of k settings
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
			0: k = 5'd16;
			1: k = 5'd0;
			2: k = 5'd31;
			3: k = 5'd1;
			4: k = 5'd5;
			6: k = 5'd10;
			7: k = 5'd3;
			default: k = tkst_pkg::CNT_BITS'($urandom_range(0, 31));
			endcase
			add_cfg(k);
			n = $urandom_range(20, 32);
			for (int i = 0; i < n; i++) begin
				if ((phase == 4 || phase == 7) && i == n / 2)
					add_drain();
				r = $urandom_range(0, 9);
				if (r == 0)
					s = '0;
				else if (r < 5)
					s = $urandom_range(1, 12) << 16;
				else if (r == 5)
					s = $urandom_range(0, 1) ? '1 : 32'd1;
				else
					s = $urandom;
				c = $urandom_range(0, 99);
				if (c < 84)
					add_item(tkst_pkg::CMD_OFFER, s,
						tkst_pkg::ID_BITS'($urandom_range(0, 65535)));
				else if (c < 94)
					add_item(tkst_pkg::CMD_READ, $urandom,
						tkst_pkg::ID_BITS'($urandom_range(0, 65535)));
				else if (c < 97)
					add_item(tkst_pkg::CMD_CLEAR, $urandom,
						tkst_pkg::ID_BITS'($urandom_range(0, 65535)));
				else
					add_item(tkst_pkg::CMD_NONE, s,
						tkst_pkg::ID_BITS'($urandom_range(0, 65535)));
			end
			add_item(tkst_pkg::CMD_READ, '0, '0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (plan_q.size() > 0 || start || owed_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && owed_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tkst_pkg.sv
sv/tkst_cell.sv
sv/top_k_score_tracker.sv
tb/top_k_score_tracker_test.sv
